### rtl/core/sles_pkg.sv
package sles_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam int REG_EDGE_THRESHOLD = 0;
    localparam logic [7:0] THRESHOLD_RESET = 8'd10;

    typedef enum logic [1:0] {
        KIND_START         = 2'd0,
        KIND_SAMPLE        = 2'd1,
        KIND_END_BORDER    = 2'd2,
        KIND_END_OCCLUSION = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        EDGE_RISING    = 2'd0,
        EDGE_FALLING   = 2'd1,
        EDGE_BORDER    = 2'd2,
        EDGE_OCCLUSION = 2'd3
    } edge_type_t;

    typedef struct packed {
        logic [FIFO_CW-1:0] level;
        logic               room;
    } queue_stat_t;

endpackage

### rtl/core/sles_cfg.sv
module sles_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  edge_threshold
);
    import sles_pkg::*;

    logic [7:0] threshold_reg;
    logic       hit;

    assign hit    = (paddr[2:2] == 1'(REG_EDGE_THRESHOLD));
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (psel && penable && pwrite && hit)
        begin
            threshold_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata = {24'd0, threshold_reg};
        end
    end

    assign edge_threshold = threshold_reg;

endmodule

### rtl/core/sles_datapath.sv
module sles_datapath #(
    parameter int COORD_BITS = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [7:0]              edge_threshold,
    input  logic                    take,
    input  logic                    advance,
    input  logic [1:0]              kind,
    input  logic [COORD_BITS-1:0]   sample_position,
    input  logic [7:0]              luma,
    output logic                    stage_valid,
    output logic [1:0]              push_cnt,
    output logic [3*COORD_BITS+2:0] res0,
    output logic [3*COORD_BITS+2:0] res1
);
    import sles_pkg::*;

    localparam logic [COORD_BITS-1:0] CNT_MAX = '1;

    // input register
    logic                  stage_valid_reg;
    kind_t                 kind_reg;
    logic [COORD_BITS-1:0] pos_reg;
    logic [7:0]            luma_reg;

    // segment state
    logic [7:0]            prev_luma_reg, prev_luma_next;
    logic signed [8:0]     prev_diff_reg, prev_diff_next;
    logic [7:0]            largest_reg, largest_next;
    logic [COORD_BITS-1:0] peak_reg, peak_next;
    logic [COORD_BITS-1:0] seen_reg, seen_next;
    logic [COORD_BITS-1:0] origin_reg, origin_next;

    logic                  is_sample;
    logic                  is_end;
    logic signed [8:0]     diff;
    logic signed [8:0]     d;
    logic signed [9:0]     d10, pd10, thr10;
    logic [8:0]            mag9;
    logic [7:0]            mag;
    logic [COORD_BITS-1:0] cnt_eff;
    logic                  rising, falling, edge_hit;
    logic [7:0]            largest_base;
    logic                  peak_upd;
    logic [COORD_BITS-1:0] peak_cand;
    logic [COORD_BITS-1:0] origin_after, count_after;
    logic [3*COORD_BITS+2:0] edge_res, end_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= kind_t'(kind);
            pos_reg  <= sample_position;
            luma_reg <= luma;
        end
    end

    assign stage_valid = stage_valid_reg;

    assign is_sample = (kind_reg == KIND_SAMPLE);
    assign is_end    = (kind_reg == KIND_END_BORDER) || (kind_reg == KIND_END_OCCLUSION);

    assign diff  = $signed({1'b0, luma_reg}) - $signed({1'b0, prev_luma_reg});
    assign d     = is_sample ? diff : 9'sd0;
    assign d10   = {d[8], d};
    assign pd10  = {prev_diff_reg[8], prev_diff_reg};
    assign thr10 = $signed({2'b00, edge_threshold});

    assign cnt_eff = (is_sample && (seen_reg != CNT_MAX)) ? seen_reg + 1'b1 : seen_reg;

    assign rising   = (pd10 >= thr10) && (d10 < thr10);
    assign falling  = !rising && (pd10 <= -thr10) && (d10 > -thr10);
    assign edge_hit = (is_sample || is_end) && (rising || falling);

    assign mag9         = d[8] ? 9'(-d) : 9'(d);
    assign mag          = mag9[7:0];
    assign largest_base = edge_hit ? 8'd0 : largest_reg;
    assign peak_upd     = (mag > largest_base);
    assign peak_cand    = (pos_reg == '0) ? '0 : pos_reg - 1'b1;

    assign origin_after = edge_hit ? peak_reg : origin_reg;
    assign count_after  = edge_hit ? '0 : cnt_eff;

    assign edge_res = {peak_reg, rising ? EDGE_RISING : EDGE_FALLING,
                       origin_reg, cnt_eff, is_sample};
    assign end_res  = {pos_reg, 2'(kind_reg), origin_after, count_after, 1'b1};

    assign res0 = edge_hit ? edge_res : end_res;
    assign res1 = end_res;

    always_comb
    begin
        push_cnt = 2'd0;
        if (stage_valid_reg)
        begin
            case (kind_reg)
                KIND_START:  push_cnt = 2'd0;
                KIND_SAMPLE: push_cnt = edge_hit ? 2'd1 : 2'd0;
                default:     push_cnt = edge_hit ? 2'd2 : 2'd1;
            endcase
        end
    end

    always_comb
    begin
        prev_luma_next = prev_luma_reg;
        prev_diff_next = prev_diff_reg;
        largest_next   = largest_reg;
        peak_next      = peak_reg;
        seen_next      = seen_reg;
        origin_next    = origin_reg;
        case (kind_reg)
            KIND_START:
            begin
                origin_next    = pos_reg;
                prev_luma_next = luma_reg;
                prev_diff_next = '0;
                largest_next   = '0;
                peak_next      = '0;
                seen_next      = '0;
            end
            default:
            begin
                seen_next    = count_after;
                origin_next  = origin_after;
                largest_next = peak_upd ? mag : largest_base;
                peak_next    = peak_upd ? peak_cand : peak_reg;
                if (is_sample)
                begin
                    prev_luma_next = luma_reg;
                    prev_diff_next = diff;
                end
                else
                begin
                    prev_diff_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_luma_reg <= '0;
            prev_diff_reg <= '0;
            largest_reg   <= '0;
            peak_reg      <= '0;
            seen_reg      <= '0;
            origin_reg    <= '0;
        end
        else if (advance)
        begin
            prev_luma_reg <= prev_luma_next;
            prev_diff_reg <= prev_diff_next;
            largest_reg   <= largest_next;
            peak_reg      <= peak_next;
            seen_reg      <= seen_next;
            origin_reg    <= origin_next;
        end
    end

endmodule

### rtl/core/sles_out_queue.sv
module sles_out_queue #(
    parameter int W = 33
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            push_cnt,
    input  logic [W-1:0]          din0,
    input  logic [W-1:0]          din1,
    input  logic                  pop,
    output logic [W-1:0]          dout,
    output logic                  avail,
    output sles_pkg::queue_stat_t stat
);
    import sles_pkg::*;

    logic [W-1:0]         mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   level_reg, level_next;
    logic [FIFO_AW-1:0]   wr_ptr_inc;

    assign wr_ptr_inc  = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
    assign level_next  = level_reg + FIFO_CW'(push_cnt) - FIFO_CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= din0;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_inc] <= din1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign dout       = mem[rd_ptr_reg];
    assign avail      = (level_reg != '0);
    assign stat.level = level_reg;
    assign stat.room  = (level_reg <= FIFO_CW'(FIFO_DEPTH - 2));

endmodule

### rtl/core/scanline_luma_edge_segmenter_core.sv
// Scanline edge segmenter: takes one item per cycle unless sample_stall is high (start,
// sample, border end or occlusion end) and reports rising/falling edges and segment ends.
// An accepted item is held in the input register; its results enter a four-entry result
// queue when that register advances, and the queue head drives the outputs. A start or
// sample item yields at most one result, and while edge_stall is low the block sustains
// one item per cycle; an end item that flushes a pending edge yields two results, so over
// a run of those the output side limits the rate. The input register advances only when
// the queue has two free entries; otherwise sample_stall is raised while it is occupied.
module scanline_luma_edge_segmenter_core #(
    parameter int COORD_BITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  logic [1:0]            kind,
    input  logic [COORD_BITS-1:0] sample_position,
    input  logic [7:0]            luma,
    output logic                  edge_valid,
    input  logic                  edge_stall,
    output logic [COORD_BITS-1:0] edge_position,
    output logic [1:0]            edge_type,
    output logic [COORD_BITS-1:0] segment_begin,
    output logic [COORD_BITS-1:0] sample_count,
    output logic                  last
);
    import sles_pkg::*;

    localparam int RES_W = 3 * COORD_BITS + 3;

    logic [7:0]       edge_threshold;
    logic             stage_valid;
    logic             take;
    logic             advance;
    logic             pop;
    logic [1:0]       push_cnt;
    logic [RES_W-1:0] res0, res1, head;
    queue_stat_t      stat;

    sles_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .edge_threshold (edge_threshold)
    );

    assign advance      = stage_valid && stat.room;
    assign sample_stall = stage_valid && !stat.room;
    assign take         = sample_valid && !sample_stall;

    sles_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .edge_threshold  (edge_threshold),
        .take            (take),
        .advance         (advance),
        .kind            (kind),
        .sample_position (sample_position),
        .luma            (luma),
        .stage_valid     (stage_valid),
        .push_cnt        (push_cnt),
        .res0            (res0),
        .res1            (res1)
    );

    assign pop = edge_valid && !edge_stall;

    sles_out_queue #(
        .W (RES_W)
    ) u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (advance ? push_cnt : 2'd0),
        .din0     (res0),
        .din1     (res1),
        .pop      (pop),
        .dout     (head),
        .avail    (edge_valid),
        .stat     (stat)
    );

    assign {edge_position, edge_type, segment_begin, sample_count, last} = head;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.level <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_flush_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        edge_valid && !last |-> (edge_type == EDGE_RISING) || (edge_type == EDGE_FALLING))
        else $error("non-final result is not an edge");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        edge_valid && ((edge_type == EDGE_BORDER) || (edge_type == EDGE_OCCLUSION)) |-> last)
        else $error("segment end result not marked last");

    a_stall_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |=> stage_valid)
        else $error("input register emptied while stalled");

endmodule
